// ===== rtl/core/dgts_pkg.sv =====
// dgts_pkg: frame geometry, field widths, register map and result type
// shared by the depth grid triangle stitcher modules
// no dependencies
package dgts_pkg;

  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;

  localparam int DEPTH_W = 16;
  localparam int IDX_W   = 19;
  localparam int COL_W   = $clog2(FRAME_WIDTH);
  localparam int ROW_W   = $clog2(FRAME_HEIGHT);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_MAX_JUMP = 1'b0;
  localparam logic [DEPTH_W-1:0] MAX_JUMP_RESET = 16'd100;

  typedef struct packed {
    logic [IDX_W-1:0] top_left_index;
    logic [IDX_W-1:0] top_right_index;
    logic [IDX_W-1:0] bottom_left_index;
    logic [IDX_W-1:0] bottom_right_index;
    logic             upper_valid;
    logic             lower_valid;
  } dgts_result_t;

endpackage

// ===== rtl/core/depth_grid_triangle_stitcher_unit.sv =====
// depth_grid_triangle_stitcher_unit: top level, line store as a chain of
// dgts_cell stages, triangle checks, result queue and the max_jump register
// uses dgts_pkg, dgts_cell, dgts_tri_check, dgts_out_queue
//
//   channel   handshake             payload
//   in_       in_valid / in_ready   in_depth_mm[15:0], in_frame_start
//   out_      out_valid / out_ready out_*_index[18:0] x4, out_upper_valid, out_lower_valid
//   config    psel/penable/pwrite   paddr[2:0], pwdata[31:0], prdata[31:0], pready
//
// one request per cycle while in_ready is high; each result is registered in the queue before out_valid shows it
// the line store is a 640-stage shift chain that moves once per accepted request
// the two-entry result queue keeps in_ready high while one result waits
// rst_n clears position, neighbor depths, queue and sets max_jump to 100
// line store contents are not cleared; raster order writes them before use
module depth_grid_triangle_stitcher_unit
  import dgts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DEPTH_W-1:0] in_depth_mm,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   out_top_left_index,
  output logic [IDX_W-1:0]   out_top_right_index,
  output logic [IDX_W-1:0]   out_bottom_left_index,
  output logic [IDX_W-1:0]   out_bottom_right_index,
  output logic               out_upper_valid,
  output logic               out_lower_valid,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [COL_W-1:0]   col_r;
  logic [COL_W-1:0]   col_nxt;
  logic [ROW_W-1:0]   row_r;
  logic [ROW_W-1:0]   row_nxt;
  logic [IDX_W-1:0]   base_r;
  logic [IDX_W-1:0]   base_nxt;
  logic [DEPTH_W-1:0] left_r;
  logic [DEPTH_W-1:0] left_nxt;
  logic [DEPTH_W-1:0] uleft_r;
  logic [DEPTH_W-1:0] uleft_nxt;
  logic [DEPTH_W-1:0] max_jump_r;
  logic [DEPTH_W-1:0] max_jump_nxt;

  logic               accept;
  logic               push;
  logic               q_full;
  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic [IDX_W-1:0]   cur_base;
  logic [IDX_W-1:0]   up_base;
  logic [IDX_W-1:0]   col_ext;
  logic [DEPTH_W-1:0] up_depth;
  logic               upper_ok;
  logic               lower_ok;
  logic               cfg_wr;
  dgts_result_t       res;
  dgts_result_t       q_out;

  logic [DEPTH_W-1:0] chain [FRAME_WIDTH+1];

  assign accept = in_valid && in_ready;
  assign in_ready = !q_full;

  // line store: depth of the same column one row back sits at the chain end
  assign chain[0] = in_depth_mm;
  for (genvar i = 0; i < FRAME_WIDTH; i++) begin : g_line
    dgts_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .depth_in (chain[i]),
      .depth_out(chain[i+1])
    );
  end
  assign up_depth = chain[FRAME_WIDTH];

  assign cur_col  = in_frame_start ? '0 : col_r;
  assign cur_row  = in_frame_start ? '0 : row_r;
  assign cur_base = in_frame_start ? '0 : base_r;
  assign up_base  = cur_base - IDX_W'(FRAME_WIDTH);
  assign col_ext  = {{(IDX_W-COL_W){1'b0}}, cur_col};

  dgts_tri_check u_upper (
    .corner_a(uleft_r),
    .corner_b(up_depth),
    .corner_c(left_r),
    .limit   (max_jump_r),
    .tri_ok  (upper_ok)
  );

  dgts_tri_check u_lower (
    .corner_a(in_depth_mm),
    .corner_b(up_depth),
    .corner_c(left_r),
    .limit   (max_jump_r),
    .tri_ok  (lower_ok)
  );

  always_comb begin
    res.bottom_right_index = cur_base + col_ext;
    res.bottom_left_index  = cur_base + col_ext - IDX_W'(1);
    res.top_right_index    = up_base + col_ext;
    res.top_left_index     = up_base + col_ext - IDX_W'(1);
    res.upper_valid        = upper_ok;
    res.lower_valid        = lower_ok;
  end

  // a cell closes once left, upper and upper-left neighbors exist
  assign push = accept && (cur_col != '0) && (cur_row != '0);

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    base_nxt  = base_r;
    left_nxt  = left_r;
    uleft_nxt = uleft_r;
    if (accept) begin
      left_nxt  = in_depth_mm;
      uleft_nxt = up_depth;
      if (cur_col == COL_W'(FRAME_WIDTH - 1)) begin
        col_nxt = '0;
        if (cur_row == ROW_W'(FRAME_HEIGHT - 1)) begin
          row_nxt  = '0;
          base_nxt = '0;
        end else begin
          row_nxt  = cur_row + ROW_W'(1);
          base_nxt = cur_base + IDX_W'(FRAME_WIDTH);
        end
      end else begin
        col_nxt  = cur_col + COL_W'(1);
        row_nxt  = cur_row;
        base_nxt = cur_base;
      end
    end
  end

  assign cfg_wr       = psel && penable && pwrite && pready;
  assign max_jump_nxt = (cfg_wr && (paddr[2] == REG_MAX_JUMP)) ? pwdata[DEPTH_W-1:0]
                                                                 : max_jump_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      base_r     <= '0;
      left_r     <= '0;
      uleft_r    <= '0;
      max_jump_r <= MAX_JUMP_RESET;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      base_r     <= base_nxt;
      left_r     <= left_nxt;
      uleft_r    <= uleft_nxt;
      max_jump_r <= max_jump_nxt;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_JUMP) ? {{(DATA_W-DEPTH_W){1'b0}}, max_jump_r} : '0;

  dgts_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(res),
    .full     (q_full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (q_out)
  );

  assign out_top_left_index     = q_out.top_left_index;
  assign out_top_right_index    = q_out.top_right_index;
  assign out_bottom_left_index  = q_out.bottom_left_index;
  assign out_bottom_right_index = q_out.bottom_right_index;
  assign out_upper_valid        = q_out.upper_valid;
  assign out_lower_valid        = q_out.lower_valid;

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r < COL_W'(FRAME_WIDTH)) && (row_r < ROW_W'(FRAME_HEIGHT)))
    else $error("pixel position outside frame");

  a_base_tracks_row: assert property (@(posedge clk) disable iff (!rst_n)
    base_r == IDX_W'(row_r) * IDX_W'(FRAME_WIDTH))
    else $error("row base out of step with row position");

  a_no_cell_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_frame_start) |-> !push)
    else $error("result produced for first pixel of a frame");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !out_ready) |=> (out_valid && !in_ready) || out_ready)
    else $error("result queue dropped an entry while stalled");

endmodule

// ===== rtl/core/dgts_cell.sv =====
// dgts_cell: one stage of the line store, holds one depth sample
// and passes it to the next stage on each accepted request; uses dgts_pkg
module dgts_cell
  import dgts_pkg::*;
(
  input  logic               clk,
  input  logic               shift_en,
  input  logic [DEPTH_W-1:0] depth_in,
  output logic [DEPTH_W-1:0] depth_out
);

  logic [DEPTH_W-1:0] depth_r;
  logic [DEPTH_W-1:0] depth_nxt;

  assign depth_nxt = shift_en ? depth_in : depth_r;

  always_ff @(posedge clk) begin
    depth_r <= depth_nxt;
  end

  assign depth_out = depth_r;

endmodule

// ===== rtl/core/dgts_tri_check.sv =====
// dgts_tri_check: checks that every edge step of one triangle is below the limit
// uses dgts_pkg
module dgts_tri_check
  import dgts_pkg::*;
(
  input  logic [DEPTH_W-1:0] corner_a,
  input  logic [DEPTH_W-1:0] corner_b,
  input  logic [DEPTH_W-1:0] corner_c,
  input  logic [DEPTH_W-1:0] limit,
  output logic               tri_ok
);

  logic [DEPTH_W-1:0] step_ab;
  logic [DEPTH_W-1:0] step_bc;
  logic [DEPTH_W-1:0] step_ca;

  assign step_ab = (corner_a >= corner_b) ? corner_a - corner_b : corner_b - corner_a;
  assign step_bc = (corner_b >= corner_c) ? corner_b - corner_c : corner_c - corner_b;
  assign step_ca = (corner_c >= corner_a) ? corner_c - corner_a : corner_a - corner_c;

  // max of the three below limit is the same as each below limit
  assign tri_ok = (step_ab < limit) && (step_bc < limit) && (step_ca < limit);

endmodule

// ===== rtl/core/dgts_out_queue.sv =====
// dgts_out_queue: two-entry result queue between the cell logic and the
// result channel; uses dgts_pkg
module dgts_out_queue
  import dgts_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  dgts_result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_ready,
  output dgts_result_t out_data
);

  logic [1:0]   cnt_r;
  logic [1:0]   cnt_nxt;
  dgts_result_t slot0_r;
  dgts_result_t slot0_nxt;
  dgts_result_t slot1_r;
  dgts_result_t slot1_nxt;
  logic         pop;

  assign pop = out_valid && out_ready;

  always_comb begin
    cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, pop};
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (pop) begin
      slot0_nxt = (cnt_r == 2'd2) ? slot1_r : push_data;
    end else if (push && (cnt_r == 2'd0)) begin
      slot0_nxt = push_data;
    end
    if (push && (((cnt_r == 2'd1) && !pop) || ((cnt_r == 2'd2) && pop))) begin
      slot1_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;

endmodule
